>>> design/rsu_pkg.sv
// ============================================================================
// rsu_pkg
// Shared types, constants and character helpers for the radix string parser.
// ============================================================================
package rsu_pkg;

    localparam int WIDTH_DEFAULT   = 32;
    localparam int MAX_LEN_DEFAULT = 65535;

    localparam int RADIX_W = 6;
    localparam int INDEX_W = 16;

    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
    localparam logic [7:0] CH_UP_Z  = 8'h5A;  // 'Z'
    localparam logic [7:0] CH_LO_A  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LO_Z  = 8'h7A;  // 'z'
    localparam logic [7:0] CH_X_LO  = 8'h78;  // 'x'
    localparam logic [7:0] CH_X_UP  = 8'h58;  // 'X'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [7:0] UP_OFFSET = CH_UP_A - 8'd10;
    localparam logic [7:0] LO_OFFSET = CH_LO_A - 8'd10;

    localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;

    // no-digit code; never below any 6-bit radix
    localparam logic [RADIX_W-1:0] DIGIT_NONE = 6'd63;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LEAD   = 3'd1,
        PH_SIGNED = 3'd2,
        PH_ZERO   = 3'd3,
        PH_HEX1   = 3'd4,
        PH_DIGITS = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        DS_NONE   = 2'd0,
        DS_DIGITS = 2'd1,
        DS_OVFL   = 2'd2
    } digit_status_t;

    typedef struct packed {
        logic emit;
        logic converted;
        logic overflowed;
    } res_flags_t;

    function automatic logic [RADIX_W-1:0] char_digit(input logic [7:0] c);
        logic [RADIX_W-1:0] d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = RADIX_W'(c - CH_ZERO);
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = RADIX_W'(c - UP_OFFSET);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = RADIX_W'(c - LO_OFFSET);
        end
        return d;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

>>> design/rsu_digit_alu.sv
// ============================================================================
// rsu_digit_alu
// Multiply-add of one digit into the accumulator with overflow detection.
// ============================================================================
module rsu_digit_alu #(
    parameter int WIDTH = rsu_pkg::WIDTH_DEFAULT
) (
    input  logic [WIDTH-1:0]            acc,
    input  logic [rsu_pkg::RADIX_W-1:0] base,
    input  logic [rsu_pkg::RADIX_W-1:0] digit,
    output logic [WIDTH-1:0]            sum,
    output logic                        ovfl
);

    localparam int PROD_W = WIDTH + rsu_pkg::RADIX_W;

    logic [PROD_W-1:0] prod;

    // acc*base < 2^(WIDTH+6), and +digit cannot carry past that bound
    assign prod = PROD_W'(acc) * PROD_W'(base) + PROD_W'(digit);
    assign sum  = prod[WIDTH-1:0];
    assign ovfl = |prod[PROD_W-1:WIDTH];

endmodule

>>> design/rsu_parse_core.sv
// ============================================================================
// rsu_parse_core
// Parse state and per-character decode; one character per step.
// ============================================================================
module rsu_parse_core #(
    parameter int WIDTH   = rsu_pkg::WIDTH_DEFAULT,
    parameter int MAX_LEN = rsu_pkg::MAX_LEN_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rstn,
    input  logic                        step,
    input  logic [7:0]                  ch,
    input  logic                        start,
    input  logic [rsu_pkg::RADIX_W-1:0] radix,
    output logic [WIDTH-1:0]            res_value,
    output logic [rsu_pkg::INDEX_W-1:0] res_index,
    output rsu_pkg::res_flags_t         res_flags
);

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);
    localparam logic [31:0] INDEX_SAT = 32'((1 << rsu_pkg::INDEX_W) - 1);

    rsu_pkg::phase_t              phase_reg, phase_next, cur_phase;
    rsu_pkg::digit_status_t       status_reg, status_next, cur_status, status_in;
    logic [WIDTH-1:0]             acc_reg, acc_next, cur_acc;
    logic                         neg_reg, neg_next, cur_neg;
    logic [rsu_pkg::RADIX_W-1:0]  radix_reg, radix_next, cur_radix, eff_radix;
    logic [POS_W-1:0]             pos_reg, pos_next, cur_pos;

    logic [rsu_pkg::RADIX_W-1:0]  dval;
    logic                         first_zero, is_x, take, digit_bad;
    logic [WIDTH-1:0]             alu_sum;
    logic                         alu_ovfl;
    logic [31:0]                  idx_wide;

    // a start beat restarts the parse from this character
    assign cur_phase  = start ? rsu_pkg::PH_LEAD : phase_reg;
    assign cur_status = start ? rsu_pkg::DS_NONE : status_reg;
    assign cur_acc    = start ? '0 : acc_reg;
    assign cur_neg    = start ? 1'b0 : neg_reg;
    assign cur_radix  = start ? radix : radix_reg;
    assign cur_pos    = start ? '0 : pos_reg;

    assign dval       = rsu_pkg::char_digit(ch);
    assign is_x       = (ch == rsu_pkg::CH_X_LO) || (ch == rsu_pkg::CH_X_UP);
    assign first_zero = (ch == rsu_pkg::CH_ZERO) &&
                        ((cur_radix == rsu_pkg::RADIX_AUTO) ||
                         (cur_radix == rsu_pkg::RADIX_HEX));

    // decode: does this character go through the digit path, and in which base
    always_comb begin
        take      = 1'b0;
        eff_radix = cur_radix;
        status_in = cur_status;
        case (cur_phase)
            rsu_pkg::PH_LEAD: begin
                if (!rsu_pkg::is_space(ch) && ch != rsu_pkg::CH_MINUS &&
                    ch != rsu_pkg::CH_PLUS && !first_zero) begin
                    take = 1'b1;
                    if (cur_radix == rsu_pkg::RADIX_AUTO) eff_radix = rsu_pkg::RADIX_DEC;
                end
            end
            rsu_pkg::PH_SIGNED: begin
                if (!first_zero) begin
                    take = 1'b1;
                    if (cur_radix == rsu_pkg::RADIX_AUTO) eff_radix = rsu_pkg::RADIX_DEC;
                end
            end
            rsu_pkg::PH_ZERO: begin
                if (!is_x) begin
                    take      = 1'b1;
                    status_in = rsu_pkg::DS_DIGITS;  // the leading zero counts
                    if (cur_radix == rsu_pkg::RADIX_AUTO) eff_radix = rsu_pkg::RADIX_OCT;
                end
            end
            rsu_pkg::PH_HEX1, rsu_pkg::PH_DIGITS: begin
                take = 1'b1;
            end
            default: begin
                take = 1'b0;
            end
        endcase
    end

    assign digit_bad = (eff_radix == rsu_pkg::RADIX_AUTO) || (dval >= eff_radix);

    rsu_digit_alu #(
        .WIDTH(WIDTH)
    ) u_alu (
        .acc  (cur_acc),
        .base (eff_radix),
        .digit(dval),
        .sum  (alu_sum),
        .ovfl (alu_ovfl)
    );

    // next state
    always_comb begin
        phase_next  = cur_phase;
        status_next = status_in;
        acc_next    = cur_acc;
        neg_next    = cur_neg;
        radix_next  = cur_radix;
        pos_next    = cur_pos;
        if (cur_phase != rsu_pkg::PH_IDLE && cur_pos < POS_MAX) begin
            pos_next = cur_pos + 1'b1;
        end
        case (cur_phase)
            rsu_pkg::PH_LEAD: begin
                if (ch == rsu_pkg::CH_MINUS) begin
                    neg_next   = 1'b1;
                    phase_next = rsu_pkg::PH_SIGNED;
                end else if (ch == rsu_pkg::CH_PLUS) begin
                    phase_next = rsu_pkg::PH_SIGNED;
                end else if (first_zero && !rsu_pkg::is_space(ch)) begin
                    phase_next = rsu_pkg::PH_ZERO;
                end
            end
            rsu_pkg::PH_SIGNED: begin
                if (first_zero) phase_next = rsu_pkg::PH_ZERO;
            end
            rsu_pkg::PH_ZERO: begin
                if (is_x) begin
                    radix_next = rsu_pkg::RADIX_HEX;
                    phase_next = rsu_pkg::PH_HEX1;
                end
            end
            default: begin
                phase_next = cur_phase;
            end
        endcase
        if (take) begin
            radix_next = eff_radix;
            if (digit_bad) begin
                phase_next = rsu_pkg::PH_IDLE;
            end else begin
                phase_next = rsu_pkg::PH_DIGITS;
                // saturated value stays put
                if (status_in != rsu_pkg::DS_OVFL) begin
                    if (alu_ovfl) begin
                        status_next = rsu_pkg::DS_OVFL;
                        acc_next    = '1;
                    end else begin
                        status_next = rsu_pkg::DS_DIGITS;
                        acc_next    = alu_sum;
                    end
                end
            end
        end
    end

    // result of a terminating character
    assign idx_wide = 32'(cur_pos);

    always_comb begin
        res_flags.emit       = step && take && digit_bad;
        res_flags.converted  = (status_in != rsu_pkg::DS_NONE);
        res_flags.overflowed = (status_in == rsu_pkg::DS_OVFL);
        res_value            = cur_acc;
        if (cur_neg && status_in == rsu_pkg::DS_DIGITS) begin
            res_value = '0 - cur_acc;
        end
        res_index = '0;
        if (status_in != rsu_pkg::DS_NONE) begin
            res_index = (idx_wide > INDEX_SAT) ? INDEX_SAT[rsu_pkg::INDEX_W-1:0]
                                               : idx_wide[rsu_pkg::INDEX_W-1:0];
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            phase_reg  <= rsu_pkg::PH_IDLE;
            status_reg <= rsu_pkg::DS_NONE;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            radix_reg  <= '0;
            pos_reg    <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            status_reg <= status_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            radix_reg  <= radix_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

>>> design/radix_string_to_unsigned_parser.sv
// ============================================================================
// radix_string_to_unsigned_parser
// Streaming string-to-unsigned converter, one character byte per beat.
// ============================================================================
// Path: an accepted input beat reaches its result on m_tvalid through the input
//   register, then parse logic into the result register.
// Throughput: 1 character per cycle while the result register can take a beat;
//   one digit multiply-add per cycle in rsu_digit_alu sets the per-character work.
// Reset: aresetn (sync, active low) empties both registers and returns the
//   parser to idle with cleared accumulator, sign, radix and position.
// ============================================================================
module radix_string_to_unsigned_parser #(
    parameter  int WIDTH    = rsu_pkg::WIDTH_DEFAULT,
    parameter  int MAX_LEN  = rsu_pkg::MAX_LEN_DEFAULT,
    localparam int M_DATA_W = ((WIDTH + rsu_pkg::INDEX_W + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // character side
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] ch
    input  logic [6:0]          s_tuser,   // [0] start_req, [6:1] radix
    // result side
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [WIDTH-1:0] value, next 16 end_index, zero pad
    output logic [1:0]          m_tuser    // [0] converted, [1] overflowed
);

    localparam int PAD_W = M_DATA_W - WIDTH - rsu_pkg::INDEX_W;

    // input register
    logic                         in_valid_reg, in_valid_next;
    logic [7:0]                   in_ch_reg;
    logic                         in_start_reg;
    logic [rsu_pkg::RADIX_W-1:0]  in_radix_reg;

    // result register
    logic                         out_valid_reg, out_valid_next;
    logic [WIDTH-1:0]             out_value_reg;
    logic [rsu_pkg::INDEX_W-1:0]  out_index_reg;
    logic                         out_conv_reg;
    logic                         out_ovfl_reg;

    logic                         fire;
    logic                         s_beat;
    logic [WIDTH-1:0]             res_value;
    logic [rsu_pkg::INDEX_W-1:0]  res_index;
    rsu_pkg::res_flags_t          res_flags;
    logic                         pad_unused;

    // parse step happens when the result register can take a beat
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_beat   = s_tvalid && s_tready;

    rsu_parse_core #(
        .WIDTH  (WIDTH),
        .MAX_LEN(MAX_LEN)
    ) u_core (
        .clk      (aclk),
        .rstn     (aresetn),
        .step     (fire),
        .ch       (in_ch_reg),
        .start    (in_start_reg),
        .radix    (in_radix_reg),
        .res_value(res_value),
        .res_index(res_index),
        .res_flags(res_flags)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_beat) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    // only a terminating character produces an output beat
    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_flags.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_ch_reg    <= s_tdata;
            in_start_reg <= s_tuser[0];
            in_radix_reg <= s_tuser[6:1];
        end
        if (res_flags.emit) begin
            out_value_reg <= res_value;
            out_index_reg <= res_index;
            out_conv_reg  <= res_flags.converted;
            out_ovfl_reg  <= res_flags.overflowed;
        end
    end

    assign pad_unused = 1'b0;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {{PAD_W{pad_unused}}, out_index_reg, out_value_reg};
    assign m_tuser    = {out_ovfl_reg, out_conv_reg};

    // saturation leaves all ones
    a_ovfl_all_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_ovfl_reg |-> out_value_reg == {WIDTH{1'b1}})
        else $error("overflowed result not saturated");

    // an overflowed result has converted digits
    a_ovfl_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_ovfl_reg |-> out_conv_reg)
        else $error("overflow without conversion");

    // nothing converted gives zero value and zero index
    a_no_conv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_conv_reg |-> out_value_reg == '0 && out_index_reg == '0)
        else $error("empty conversion carries data");

    // a result beat needs a character consumed in the cycle before
    a_emit_needs_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(fire))
        else $error("result without a parse step");

endmodule
